// File: rtl/core/vtsd_pkg.sv
package vtsd_pkg;

  // Coordinates of cells and neighbors, wide enough for the padded box and grid sizes to 256
  localparam int CW = 10;
  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t PAD  = coord_t'(4);
  localparam coord_t STEP = coord_t'(3);
  localparam coord_t HALF = coord_t'(2);

  localparam int           NBR_SPAN     = 5;
  localparam logic [2:0]   NBR_LAST     = 3'd4;
  localparam logic [6:0]   FULL_COUNT   = 7'd125;
  localparam logic [16:0]  FULL_DENSITY = 17'd100000;
  localparam logic [11:0]  W_INTERIOR   = 12'd2222;
  localparam logic [11:0]  W_FACE       = 12'd463;
  localparam logic [11:0]  W_EDGE       = 12'd361;
  localparam logic [11:0]  W_CORNER     = 12'd250;

  typedef struct packed {
    logic       kind;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [5:0] pos_z;
    logic       occupied;
  } cmd_t;

  typedef struct packed {
    logic [16:0]        density;
    logic signed [7:0]  cell_x;
    logic signed [7:0]  cell_y;
    logic signed [7:0]  cell_z;
    logic               last;
    logic               box_empty;
  } res_t;

  // Control from the sequencer to the neighborhood accumulator
  typedef struct packed {
    logic       clear;
    logic       en;
    logic       row_ok;
    logic [2:0] iy;
    logic [2:0] iz;
  } acc_ctl_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  function automatic coord_t ext6(logic [5:0] v);
    return coord_t'({{(CW-6){1'b0}}, v});
  endfunction

  // Shell weight of one neighbor from its lane indexes (offset = index - 2)
  function automatic logic [11:0] lane_weight(int j, logic [2:0] iy, logic [2:0] iz);
    int dx;
    int dy;
    int dz;
    int d;
    dx = j - 2;
    dy = int'(iy) - 2;
    dz = int'(iz) - 2;
    d  = dx * dx + dy * dy + dz * dz;
    if (d > 11) return W_CORNER;
    else if (d > 7) return W_EDGE;
    else if (d > 3) return W_FACE;
    else return W_INTERIOR;
  endfunction

endpackage

// File: rtl/core/vtsd_store.sv
module vtsd_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One x row per word; write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/vtsd_accum.sv
module vtsd_accum import vtsd_pkg::*; #(
  parameter int DIM_X = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  acc_ctl_t         ctl,
  input  coord_t           cx,
  input  logic [DIM_X-1:0] row,
  output logic [16:0]      sum,
  output logic [6:0]       cnt
);

  localparam int XW = $clog2(DIM_X);

  logic [16:0] row_sum;
  logic [2:0]  row_cnt;
  logic [NBR_SPAN-1:0] bits;

  // Pick the five voxels around cx and weight them by shell
  always_comb begin
    coord_t xi;
    row_sum = '0;
    row_cnt = '0;
    for (int j = 0; j < NBR_SPAN; j++) begin
      xi = cx + coord_t'(j) - HALF;
      bits[j] = ctl.row_ok && (xi >= coord_t'(0)) && (xi < coord_t'(DIM_X)) &&
                row[xi[XW-1:0]];
      if (bits[j]) begin
        row_sum = row_sum + 17'(lane_weight(j, ctl.iy, ctl.iz));
        row_cnt = row_cnt + 3'd1;
      end
    end
  end

  // Accumulate one row per cycle while ctl.en is high
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum <= '0;
      cnt <= '0;
    end else if (ctl.en) begin
      sum <= sum + row_sum;
      cnt <= cnt + 7'(row_cnt);
    end
  end

endmodule

// File: rtl/core/voxel_third_shell_downsample_unit.sv
// Voxel density walker. A load (kind 0) is accepted, reads its x row, then writes it back.
// A request (kind 1) reads the 5x5x5 neighborhood one five-voxel x row per cycle
// from the row memory (25 rows), then passes a drain and a finish state; a request
// before any occupied voxel answers with an empty-box result and no walk. busy is high while an item is at work.
// After reset a clearing pass writes every row of the memory, all DIM_Y*DIM_Z rows (4096 at the
// defaults), with busy high. Each result is on res for one cycle with done high; the receiver
// cannot stall, so it must take every result as it appears.
module voxel_third_shell_downsample_unit import vtsd_pkg::*; #(
  parameter int DIM_X = 64,
  parameter int DIM_Y = 64,
  parameter int DIM_Z = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t res
);

  localparam int ROWS = DIM_Y * DIM_Z;
  localparam int AW   = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LD_RD = 7'b0000100,
    S_LD_WR = 7'b0001000,
    S_CELL  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t         state;
  logic [AW-1:0]  clr_addr;
  logic           seen_any;
  logic           walk_active;
  logic [5:0]     min_x, min_y, min_z, max_x, max_y, max_z;
  coord_t         cur_x, cur_y, cur_z;
  coord_t         cx, cy, cz;
  logic [5:0]     ld_x, ld_y, ld_z;
  logic           ld_occ;
  logic [2:0]     iy, iz;
  acc_ctl_t       acc_ctl;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [DIM_X-1:0] mem_wdata, rd_data;
  logic [16:0]      acc_sum;
  logic [6:0]       acc_cnt;

  coord_t yi, zi;
  logic   row_ok;
  logic   in_grid;
  coord_t nx, ny, nz;
  logic [16:0] density;

  assign busy = (state != S_IDLE);

  assign in_grid = (int'(cmd.pos_x) < DIM_X) && (int'(cmd.pos_y) < DIM_Y) &&
                   (int'(cmd.pos_z) < DIM_Z);

  // Neighbor row of the current step
  assign yi = cy + coord_t'(iy) - HALF;
  assign zi = cz + coord_t'(iz) - HALF;
  assign row_ok = (yi >= coord_t'(0)) && (yi < coord_t'(DIM_Y)) &&
                  (zi >= coord_t'(0)) && (zi < coord_t'(DIM_Z));

  // Drive the row memory
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_addr;
    mem_raddr = '0;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_LD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(ld_z) * AW'(DIM_Y) + AW'(ld_y);
      end
      S_LD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ld_z) * AW'(DIM_Y) + AW'(ld_y);
        for (int i = 0; i < DIM_X; i++) begin
          mem_wdata[i] = (i == int'(ld_x)) ? ld_occ : rd_data[i];
        end
      end
      S_CELL: begin
        mem_re = row_ok;
        if (row_ok) begin
          mem_raddr = AW'(zi) * AW'(DIM_Y) + AW'(yi);
        end
      end
      S_IDLE, S_DRAIN, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  vtsd_store #(
    .DEPTH (ROWS),
    .WIDTH (DIM_X)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  vtsd_accum #(
    .DIM_X (DIM_X)
  ) u_accum (
    .clk (clk),
    .rst (rst),
    .ctl (acc_ctl),
    .cx  (cx),
    .row (rd_data),
    .sum (acc_sum),
    .cnt (acc_cnt)
  );

  // Final density and next cursor
  assign nx = cx + STEP;
  assign ny = cy + STEP;
  assign nz = cz + STEP;
  always_comb begin
    if (acc_cnt == 7'd0) density = '0;
    else if (acc_cnt >= FULL_COUNT) density = FULL_DENSITY;
    else density = acc_sum;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      seen_any    <= 1'b0;
      walk_active <= 1'b0;
      min_x <= 6'd63; min_y <= 6'd63; min_z <= 6'd63;
      max_x <= 6'd0;  max_y <= 6'd0;  max_z <= 6'd0;
      acc_ctl     <= '0;
      done        <= 1'b0;
    end else begin
      done    <= 1'b0;
      acc_ctl <= '0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ROW) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (cmd.kind == KIND_LOAD) begin
              if (in_grid) begin
                walk_active <= 1'b0;
                ld_x   <= cmd.pos_x;
                ld_y   <= cmd.pos_y;
                ld_z   <= cmd.pos_z;
                ld_occ <= cmd.occupied;
                if (cmd.occupied) begin
                  seen_any <= 1'b1;
                  if (cmd.pos_x < min_x) min_x <= cmd.pos_x;
                  if (cmd.pos_y < min_y) min_y <= cmd.pos_y;
                  if (cmd.pos_z < min_z) min_z <= cmd.pos_z;
                  if (cmd.pos_x > max_x) max_x <= cmd.pos_x;
                  if (cmd.pos_y > max_y) max_y <= cmd.pos_y;
                  if (cmd.pos_z > max_z) max_z <= cmd.pos_z;
                end
                state <= S_LD_RD;
              end
            end else if (!seen_any) begin
              done <= 1'b1;
              res  <= '{density: '0, cell_x: '0, cell_y: '0, cell_z: '0,
                        last: 1'b1, box_empty: 1'b1};
            end else begin
              if (walk_active) begin
                cx <= cur_x; cy <= cur_y; cz <= cur_z;
              end else begin
                cx <= ext6(min_x) - PAD;
                cy <= ext6(min_y) - PAD;
                cz <= ext6(min_z) - PAD;
              end
              walk_active   <= 1'b1;
              iy            <= '0;
              iz            <= '0;
              acc_ctl.clear <= 1'b1;
              state         <= S_CELL;
            end
          end
        end
        S_LD_RD: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          state <= S_IDLE;
        end
        S_CELL: begin
          acc_ctl <= '{clear: 1'b0, en: 1'b1, row_ok: row_ok, iy: iy, iz: iz};
          if (iy == NBR_LAST) begin
            iy <= '0;
            iz <= iz + 3'd1;
            if (iz == NBR_LAST) state <= S_DRAIN;
          end else begin
            iy <= iy + 3'd1;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          done          <= 1'b1;
          res.density   <= density;
          res.cell_x    <= cx[7:0];
          res.cell_y    <= cy[7:0];
          res.cell_z    <= cz[7:0];
          res.box_empty <= 1'b0;
          res.last      <= 1'b0;
          if (nx > ext6(max_x) + PAD) begin
            cur_x <= ext6(min_x) - PAD;
            if (ny > ext6(max_y) + PAD) begin
              cur_y <= ext6(min_y) - PAD;
              cur_z <= nz;
              if (nz > ext6(max_z) + PAD) begin
                res.last    <= 1'b1;
                walk_active <= 1'b0;
              end
            end else begin
              cur_y <= ny;
              cur_z <= cz;
            end
          end else begin
            cur_x <= nx;
            cur_y <= cy;
            cur_z <= cz;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/vtsd_check.sv
module vtsd_check import vtsd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input res_t res
);

  // A result transfer never overlaps work in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

  // An empty box gives one final zero cell
  a_empty: assert property (@(posedge clk) disable iff (rst)
      (done && res.box_empty) |-> (res.density == 17'd0 && res.last))
    else $error("empty box result malformed");

  // Density stays in range
  a_range: assert property (@(posedge clk) disable iff (rst)
      done |-> (res.density <= FULL_DENSITY))
    else $error("density out of range");

  // A request either answers at once or starts work
  a_req: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && cmd.kind == KIND_REQ) |=> (busy || done))
    else $error("request dropped");

endmodule

bind voxel_third_shell_downsample_unit vtsd_check u_check (.*);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import vtsd_pkg::*;

  localparam int GRID = 64;
  localparam int VOXELS = GRID * GRID * GRID;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  res_t res;

  voxel_third_shell_downsample_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .res(res)
  );

  // Shadow copy of the block state
  bit grid_bits [VOXELS];
  bit any_set;
  int lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  bit walking;
  int cur_x, cur_y, cur_z;

  res_t cell_queue[$];
  int errors;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 600000);
    $display("tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("%s", msg);
    errors++;
  endtask

  function automatic bit voxel_read(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= GRID || y >= GRID || z >= GRID) return 1'b0;
    return grid_bits[x + GRID * (y + GRID * z)];
  endfunction

  // Sum the shell weights of the 5x5x5 neighborhood
  function automatic logic [16:0] shell_density(int cx, int cy, int cz);
    int n;
    int acc;
    int d;
    n = 0;
    acc = 0;
    for (int dz = -2; dz <= 2; dz++)
      for (int dy = -2; dy <= 2; dy++)
        for (int dx = -2; dx <= 2; dx++) begin
          if (voxel_read(cx + dx, cy + dy, cz + dz)) begin
            d = dx * dx + dy * dy + dz * dz;
            n++;
            if (d > 11) acc += 250;
            else if (d > 7) acc += 361;
            else if (d > 3) acc += 463;
            else acc += 2222;
          end
        end
    if (n == 0) return 17'd0;
    if (n >= 125) return FULL_DENSITY;
    return 17'(acc);
  endfunction

  // Advance the shadow state by one transfer and queue the cell it yields
  task automatic predict_cell(cmd_t c);
    res_t r;
    int idx;
    if (c.kind == KIND_LOAD) begin
      idx = int'(c.pos_x) + GRID * (int'(c.pos_y) + GRID * int'(c.pos_z));
      walking = 1'b0;
      grid_bits[idx] = c.occupied;
      if (c.occupied) begin
        any_set = 1'b1;
        if (c.pos_x < lo_x) lo_x = c.pos_x;
        if (c.pos_y < lo_y) lo_y = c.pos_y;
        if (c.pos_z < lo_z) lo_z = c.pos_z;
        if (c.pos_x > hi_x) hi_x = c.pos_x;
        if (c.pos_y > hi_y) hi_y = c.pos_y;
        if (c.pos_z > hi_z) hi_z = c.pos_z;
      end
      return;
    end
    r = '0;
    if (!any_set) begin
      r.last = 1'b1;
      r.box_empty = 1'b1;
      cell_queue.push_back(r);
      return;
    end
    if (!walking) begin
      cur_x = lo_x - 4;
      cur_y = lo_y - 4;
      cur_z = lo_z - 4;
      walking = 1'b1;
    end
    r.density = shell_density(cur_x, cur_y, cur_z);
    r.cell_x = 8'(cur_x);
    r.cell_y = 8'(cur_y);
    r.cell_z = 8'(cur_z);
    cur_x += 3;
    if (cur_x > hi_x + 4) begin
      cur_x = lo_x - 4;
      cur_y += 3;
      if (cur_y > hi_y + 4) begin
        cur_y = lo_y - 4;
        cur_z += 3;
        if (cur_z > hi_z + 4) begin
          r.last = 1'b1;
          walking = 1'b0;
        end
      end
    end
    cell_queue.push_back(r);
  endtask

  // Drive one item and hold it until the block takes the transfer
  task automatic send_item(cmd_t c);
    if (idle_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predict_cell(c);
  endtask

  task automatic load_voxel(int x, int y, int z, bit occ);
    cmd_t c;
    c.kind = KIND_LOAD;
    c.pos_x = 6'(x);
    c.pos_y = 6'(y);
    c.pos_z = 6'(z);
    c.occupied = occ;
    send_item(c);
  endtask

  task automatic request_cell();
    cmd_t c;
    c = cmd_t'(19'($urandom));
    c.kind = KIND_REQ;
    send_item(c);
  endtask

  // Check each result against the oldest expected cell
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (cell_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res));
      end else begin
        e = cell_queue.pop_front();
        if (res.density !== e.density)
          report_mismatch($sformatf("density %0d exp %0d", res.density, e.density));
        if (res.cell_x !== e.cell_x)
          report_mismatch($sformatf("cell_x %0d exp %0d", res.cell_x, e.cell_x));
        if (res.cell_y !== e.cell_y)
          report_mismatch($sformatf("cell_y %0d exp %0d", res.cell_y, e.cell_y));
        if (res.cell_z !== e.cell_z)
          report_mismatch($sformatf("cell_z %0d exp %0d", res.cell_z, e.cell_z));
        if (res.last !== e.last)
          report_mismatch($sformatf("last %b exp %b", res.last, e.last));
        if (res.box_empty !== e.box_empty)
          report_mismatch($sformatf("box_empty %b exp %b", res.box_empty, e.box_empty));
      end
    end
  end

  // Requests before anything is occupied, including an empty load
  task automatic test_empty_box();
    request_cell();
    load_voxel(63, 0, 63, 1'b0);
    request_cell();
  endtask

  // Walk a small box to its last cell and wrap around
  task automatic test_small_walk();
    load_voxel(10, 10, 10, 1'b1);
    load_voxel(12, 12, 12, 1'b1);
    load_voxel(11, 10, 12, 1'b1);
    repeat (66) request_cell();
    // a load mid-walk restarts the walk
    load_voxel(11, 11, 11, 1'b1);
    repeat (3) request_cell();
  endtask

  // Fill a whole neighborhood around a cell center, then clear one voxel
  task automatic test_full_block();
    for (int z = 13; z <= 17; z++)
      for (int y = 13; y <= 17; y++)
        for (int x = 13; x <= 17; x++)
          load_voxel(x, y, z, 1'b1);
    repeat (125) request_cell();
    load_voxel(15, 15, 15, 1'b0);
    repeat (20) request_cell();
  endtask

  // Clustered loads with runs of requests, plus empty loads anywhere as noise
  task automatic test_random_walks();
    int sent;
    int k;
    sent = 0;
    while (sent < 235) begin
      idle_on = !(sent > 60 && sent < 160);
      k = $urandom_range(99);
      if (k < 35) begin
        load_voxel($urandom_range(27, 18), $urandom_range(27, 18), $urandom_range(27, 18),
                   $urandom_range(99) < 80);
        sent++;
      end else if (k < 45) begin
        load_voxel($urandom_range(63), $urandom_range(63), $urandom_range(63), 1'b0);
        sent++;
      end else begin
        repeat ($urandom_range(12, 1)) begin
          request_cell();
          sent++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Corners of the grid: neighbors fall outside and cells go negative
  task automatic test_grid_corners();
    load_voxel(0, 0, 0, 1'b1);
    repeat (30) request_cell();
    load_voxel(63, 63, 63, 1'b1);
    repeat (30) request_cell();
    load_voxel(63, 63, 63, 1'b0);
    repeat (5) request_cell();
  endtask

  initial begin
    errors = 0;
    idle_on = 1'b1;
    any_set = 1'b0;
    walking = 1'b0;
    lo_x = 63; lo_y = 63; lo_z = 63;
    hi_x = 0; hi_y = 0; hi_z = 0;
    cur_x = 0; cur_y = 0; cur_z = 0;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_box();
    test_small_walk();
    test_full_block();
    test_random_walks();
    test_grid_corners();

    start <= 1'b0;
    // drain until every expected result has been checked, with a bound on the wait
    for (int w = 0; w < 2000 && cell_queue.size() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && cell_queue.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
